>>> sv/mm_pkg.sv
// Shared types, constants and helpers for the matrix multiply block.
package mm_pkg;

	localparam int MAX_DIM  = 8;
	localparam int IDX_W    = $clog2(MAX_DIM);
	localparam int DIM_W    = $clog2(MAX_DIM + 1);
	localparam int AW       = $clog2(MAX_DIM * MAX_DIM);
	localparam int FLUSH_W  = $clog2(MAX_DIM + 1);
	localparam int FIELD_W  = 3;
	localparam int VAL_W    = 16;
	localparam int PROD_W   = 35;
	localparam int CFG_W    = 4;

	typedef enum logic [1:0] {
		ACT_LOAD_X = 2'd0,
		ACT_LOAD_W = 2'd1,
		ACT_START  = 2'd2,
		ACT_NONE   = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		REG_X_ROWS = 2'd0,
		REG_X_COLS = 2'd1,
		REG_W_ROWS = 2'd2,
		REG_W_COLS = 2'd3
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FEED,
		ST_FLUSH,
		ST_EMIT,
		ST_ERR
	} state_t;

	// one X element travelling down the cell chain
	typedef struct packed {
		logic                    valid;
		logic                    first;
		logic [IDX_W-1:0]        p;
		logic signed [VAL_W-1:0] x;
	} tok_t;

	// zero reads as one, anything above MAX_DIM saturates
	function automatic logic [DIM_W-1:0] dim_used(input logic [CFG_W-1:0] v);
		logic [DIM_W-1:0] d;
		if (v == '0)
			d = DIM_W'(1);
		else if (int'(v) > MAX_DIM)
			d = DIM_W'(MAX_DIM);
		else
			d = DIM_W'(v);
		return d;
	endfunction

endpackage

>>> sv/mm_cell.sv
// One column cell: holds a column of W and accumulates one dot product.
module mm_cell (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  mm_pkg::tok_t                         tok_in,
	output mm_pkg::tok_t                         tok_out,
	input  logic                                 w_we,
	input  logic [mm_pkg::IDX_W-1:0]             w_row,
	input  logic signed [mm_pkg::VAL_W-1:0]      w_data,
	output logic signed [mm_pkg::PROD_W-1:0]     acc
);
	import mm_pkg::*;

	logic signed [VAL_W-1:0]   w_q [MAX_DIM];
	logic signed [PROD_W-1:0]  acc_q;
	logic signed [2*VAL_W-1:0] prod;
	tok_t                      tok_q;

	always_ff @(posedge clk) begin
		if (w_we)
			w_q[w_row] <= w_data;
	end

	assign prod = tok_in.x * w_q[tok_in.p];

	always_ff @(posedge clk) begin
		if (tok_in.valid)
			acc_q <= (tok_in.first ? '0 : acc_q) + PROD_W'(prod);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_in;
		end
	end

	assign tok_out = tok_q;
	assign acc     = acc_q;

endmodule

>>> sv/mm_xram.sv
// Storage for matrix X: one write port, one registered read port.
module mm_xram (
	input  logic                            clk,
	input  logic                            we,
	input  logic [mm_pkg::AW-1:0]           waddr,
	input  logic signed [mm_pkg::VAL_W-1:0] wdata,
	input  logic [mm_pkg::AW-1:0]           raddr,
	output logic signed [mm_pkg::VAL_W-1:0] rdata
);
	import mm_pkg::*;

	logic signed [VAL_W-1:0] mem [MAX_DIM*MAX_DIM];
	logic signed [VAL_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> sv/matrix_multiply.sv
// Matrix multiply top: config registers, sequencer, X storage and the cell chain.
//
//  channel   dir  transaction
//  s_*       in   tuser=action; tdata={value,col,row}: loads or start
//  m_*       out  tuser=status; tlast=last; tdata={product,col,row}
//  apb       in   four 4-bit dimension registers at 0x0,0x4,0x8,0xC
//
// A start feeds each output row through the cell chain, lets the chain
// drain, then hands out the row's w_cols results (held while m_tready
// stalls), one MAC per cell per cycle while a row is fed.
// Reset clears control only; X and W contents stay undefined until loaded.
// s_tready is low while a start is in progress.
module matrix_multiply (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // row[2:0], col[5:3], element_value[21:6], zero pad
	input  logic [1:0]  s_tuser,   // action[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // out_row[2:0], out_col[5:3], product_value[40:6], pad
	output logic        m_tuser,   // status[0]
	output logic        m_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import mm_pkg::*;

	// configuration
	logic [CFG_W-1:0] x_rows_q, x_cols_q, w_rows_q, w_cols_q;
	logic             cfg_wr;
	reg_idx_t         cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_rows_q <= CFG_W'(8);
			x_cols_q <= CFG_W'(8);
			w_rows_q <= CFG_W'(8);
			w_cols_q <= CFG_W'(8);
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_X_ROWS: x_rows_q <= pwdata[CFG_W-1:0];
				REG_X_COLS: x_cols_q <= pwdata[CFG_W-1:0];
				REG_W_ROWS: w_rows_q <= pwdata[CFG_W-1:0];
				REG_W_COLS: w_cols_q <= pwdata[CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_X_ROWS: prdata = 32'(x_rows_q);
			REG_X_COLS: prdata = 32'(x_cols_q);
			REG_W_ROWS: prdata = 32'(w_rows_q);
			REG_W_COLS: prdata = 32'(w_cols_q);
			default:    prdata = '0;
		endcase
	end

	logic [DIM_W-1:0] xr, xc, wr, wc;
	assign xr = dim_used(x_rows_q);
	assign xc = dim_used(x_cols_q);
	assign wr = dim_used(w_rows_q);
	assign wc = dim_used(w_cols_q);

	// input fields
	action_t                 in_act;
	logic [FIELD_W-1:0]      in_row, in_col;
	logic signed [VAL_W-1:0] in_val;
	logic                    in_fire, in_pos_ok;

	assign in_act    = action_t'(s_tuser);
	assign in_row    = s_tdata[2:0];
	assign in_col    = s_tdata[5:3];
	assign in_val    = s_tdata[21:6];
	assign in_fire   = s_tvalid && s_tready;
	assign in_pos_ok = (int'(in_row) < MAX_DIM) && (int'(in_col) < MAX_DIM);

	// sequencer
	state_t             state_q, state_d;
	logic [IDX_W-1:0]   r_q, r_d, p_q, p_d, c_q, c_d;
	logic [FLUSH_W-1:0] fl_q, fl_d;
	logic               rd_en;
	logic               out_ld, out_err, out_last;

	logic               r_end, p_end, c_end;
	assign r_end = (r_q == IDX_W'(xr - DIM_W'(1)));
	assign p_end = (p_q == IDX_W'(xc - DIM_W'(1)));
	assign c_end = (c_q == IDX_W'(wc - DIM_W'(1)));

	logic out_free;
	logic m_tvalid_q;
	assign out_free = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			r_q     <= '0;
			p_q     <= '0;
			c_q     <= '0;
			fl_q    <= '0;
		end else begin
			state_q <= state_d;
			r_q     <= r_d;
			p_q     <= p_d;
			c_q     <= c_d;
			fl_q    <= fl_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		r_d      = r_q;
		p_d      = p_q;
		c_d      = c_q;
		fl_d     = fl_q;
		s_tready = 1'b0;
		rd_en    = 1'b0;
		out_ld   = 1'b0;
		out_err  = 1'b0;
		out_last = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (in_fire && in_act == ACT_START) begin
					r_d = '0;
					p_d = '0;
					if (xc != wr)
						state_d = ST_ERR;
					else
						state_d = ST_FEED;
				end
			end
			ST_FEED: begin
				rd_en = 1'b1;
				if (p_end) begin
					fl_d    = '0;
					state_d = ST_FLUSH;
				end else begin
					p_d = p_q + IDX_W'(1);
				end
			end
			ST_FLUSH: begin
				// wait for the last element to pass the final cell
				if (fl_q == FLUSH_W'(MAX_DIM)) begin
					c_d     = '0;
					state_d = ST_EMIT;
				end else begin
					fl_d = fl_q + FLUSH_W'(1);
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					out_ld   = 1'b1;
					out_last = r_end && c_end;
					if (c_end) begin
						if (r_end) begin
							state_d = ST_IDLE;
						end else begin
							r_d     = r_q + IDX_W'(1);
							p_d     = '0;
							state_d = ST_FEED;
						end
					end else begin
						c_d = c_q + IDX_W'(1);
					end
				end
			end
			ST_ERR: begin
				if (out_free) begin
					out_ld   = 1'b1;
					out_err  = 1'b1;
					out_last = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// X storage
	logic                    x_we;
	logic [AW-1:0]           x_waddr, x_raddr;
	logic signed [VAL_W-1:0] x_rdata;

	assign x_we    = in_fire && in_act == ACT_LOAD_X && in_pos_ok;
	assign x_waddr = AW'(AW'(in_row) * AW'(MAX_DIM) + AW'(in_col));
	assign x_raddr = AW'(AW'(r_q) * AW'(MAX_DIM) + AW'(p_q));

	mm_xram u_xram (
		.clk   (clk),
		.we    (x_we),
		.waddr (x_waddr),
		.wdata (in_val),
		.raddr (x_raddr),
		.rdata (x_rdata)
	);

	// read side-band, aligned with the registered RAM data
	logic             rd_s1, first_s1;
	logic [IDX_W-1:0] p_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_s1    <= 1'b0;
			first_s1 <= 1'b0;
			p_s1     <= '0;
		end else begin
			rd_s1    <= rd_en;
			first_s1 <= (p_q == '0);
			p_s1     <= p_q;
		end
	end

	// cell chain
	tok_t                     tok [MAX_DIM+1];
	logic signed [PROD_W-1:0] acc [MAX_DIM];
	logic                     w_load;

	assign w_load = in_fire && in_act == ACT_LOAD_W && in_pos_ok;
	assign tok[0] = '{valid: rd_s1, first: first_s1, p: p_s1, x: x_rdata};

	for (genvar k = 0; k < MAX_DIM; k++) begin : g_cell
		mm_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.tok_in  (tok[k]),
			.tok_out (tok[k+1]),
			.w_we    (w_load && (in_col == FIELD_W'(k))),
			.w_row   (in_row[IDX_W-1:0]),
			.w_data  (in_val),
			.acc     (acc[k])
		);
	end

	// result register
	logic [FIELD_W-1:0]       o_row_q, o_col_q;
	logic signed [PROD_W-1:0] o_prod_q;
	logic                     o_status_q, o_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid_q <= 1'b0;
		else if (out_ld)
			m_tvalid_q <= 1'b1;
		else if (m_tready)
			m_tvalid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_ld) begin
			o_row_q    <= out_err ? '0 : FIELD_W'(r_q);
			o_col_q    <= out_err ? '0 : FIELD_W'(c_q);
			o_prod_q   <= out_err ? '0 : acc[c_q];
			o_status_q <= out_err;
			o_last_q   <= out_last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {7'b0, o_prod_q, o_col_q, o_row_q};
	assign m_tuser  = o_status_q;
	assign m_tlast  = o_last_q;

	a_flush_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT |-> !tok[MAX_DIM].valid && !rd_s1)
		else $error("results read before the chain drained");

	a_err_only_mismatch: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ERR |-> xc != wr)
		else $error("error state without dimension mismatch");

	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE && state_q != ST_ERR |-> DIM_W'(r_q) < xr)
		else $error("row counter out of range");

	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast && m_tdata[40:6] == '0)
		else $error("error result malformed");

endmodule
